// ----- design/spd_pkg.sv -----
`default_nettype none

package spd_pkg;

   // Framing bytes and the descriptor/field pairs that the parser recognizes.
   localparam logic [7:0] SYNC_FIRST   = 8'h75;
   localparam logic [7:0] SYNC_SECOND  = 8'h65;
   localparam logic [7:0] DESC_EULER   = 8'h82;
   localparam logic [7:0] FIELD_EULER  = 8'h05;
   localparam logic [7:0] DESC_COMMAND = 8'h01;
   localparam logic [7:0] FIELD_REPLY  = 8'hF1;

   // Payload byte positions of the Euler record.
   localparam logic [7:0] POS_FIELD      = 8'd1;
   localparam logic [7:0] POS_ANGLE_LO   = 8'd2;
   localparam logic [7:0] POS_FLAGS_LO   = 8'd14;
   localparam logic [7:0] POS_FLAGS_HI   = 8'd15;

   localparam int ANGLE_COUNT = 3;

   typedef enum logic [6:0] {
      PH_HUNT1 = 7'b0000001,
      PH_HUNT2 = 7'b0000010,
      PH_DESC  = 7'b0000100,
      PH_LEN   = 7'b0001000,
      PH_BODY  = 7'b0010000,
      PH_CK1   = 7'b0100000,
      PH_CK2   = 7'b1000000
   } spd_phase_type;

   typedef enum logic [1:0] {
      KIND_EULER   = 2'd0,
      KIND_REPLY   = 2'd1,
      KIND_OTHER   = 2'd2,
      KIND_UNKNOWN = 2'd3
   } spd_kind_type;

endpackage

`default_nettype wire

// ----- design/sensor_packet_deframer.sv -----
// Byte-serial deframer for sync/length framed sensor packets.
// The req_ channel carries one received link byte per transaction. The parser
// hunts for the sync pair 0x75 0x65, reads a descriptor and a length byte, then
// consumes the payload and a two-byte trailer. A Fletcher-16 style pair of
// running sums covers the header and payload and is compared to the trailer.
// The rsp_ channel carries one transaction per finished packet: the kind and
// checksum status in tuser, the header codes, Euler angles and flags in tdata.
// Each byte needs a single pass of next-state logic between the parser
// registers, so one byte is accepted in every clock cycle except for the stall
// below; a result appears in the cycle after its last trailer byte is accepted.
// A finished result sits in the output register while further bytes keep
// flowing in; only the last trailer byte of the next packet waits if the
// receiver has still not taken the previous result.
// A synchronous reset returns the parser to the hunt for the first sync byte
// and empties the output register. A packet with a bad checksum is still
// reported, with checksum_ok low.
`default_nettype none

module sensor_packet_deframer (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic [7:0]     req_tdata,   // [7:0] rx_byte
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output logic [135:0]        rsp_tdata,   // [7:0] descriptor_code, [15:8] field_code,
                                            // [23:16] payload_length, [55:24] roll_bits,
                                            // [87:56] pitch_bits, [119:88] yaw_bits,
                                            // [135:120] status_flags
   output logic [2:0]          rsp_tuser    // [1:0] packet_kind, [2] checksum_ok
);
   import spd_pkg::*;

   // Parser state.
   spd_phase_type phase_ff, phase_in;
   logic [7:0]    pos_ff, pos_in;
   logic [7:0]    length_ff, length_in;
   logic [7:0]    desc_ff, desc_in;
   logic [7:0]    field_ff, field_in;
   logic [7:0]    sum_a_ff, sum_a_in;
   logic [7:0]    sum_b_ff, sum_b_in;
   logic [7:0]    trailer_ff, trailer_in;
   logic [31:0]   angle_ff [ANGLE_COUNT];
   logic [31:0]   angle_in [ANGLE_COUNT];
   logic [15:0]   flags_ff, flags_in;

   // Output register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    kind_ff;
   logic          ck_ok_ff;
   logic [7:0]    out_desc_ff, out_field_ff, out_length_ff;
   logic [31:0]   out_roll_ff, out_pitch_ff, out_yaw_ff;
   logic [15:0]   out_flags_ff;

   logic          req_fire;
   logic          emit;
   logic [7:0]    rx;
   logic [7:0]    add_a;
   logic [7:0]    add_b;
   logic [8:0]    pos_next;
   logic [7:0]    angle_off;
   logic [1:0]    angle_idx;
   spd_kind_type  kind;
   logic          ck_ok;

   assign rx       = req_tdata;
   // The last trailer byte needs the output register; it waits only while the
   // previous result is still pending.
   assign req_tready = (phase_ff != PH_CK2) || !rsp_valid_ff;
   assign req_fire = req_tvalid && req_tready;
   assign emit     = req_fire && (phase_ff == PH_CK2);

   // One step of the running sums: A += byte, B += new A.
   assign add_a    = sum_a_ff + rx;
   assign add_b    = sum_b_ff + add_a;
   assign pos_next = {1'b0, pos_ff} + 9'd1;
   assign angle_off = pos_ff - POS_ANGLE_LO;
   assign angle_idx = angle_off[3:2];

   always_comb begin
      priority if (desc_ff == DESC_EULER && field_ff == FIELD_EULER) begin
         kind = KIND_EULER;
      end else if (desc_ff == DESC_COMMAND && field_ff == FIELD_REPLY) begin
         kind = KIND_REPLY;
      end else if (desc_ff == DESC_EULER || desc_ff == DESC_COMMAND) begin
         kind = KIND_OTHER;
      end else begin
         kind = KIND_UNKNOWN;
      end
   end

   assign ck_ok = (trailer_ff == sum_a_ff) && (rx == sum_b_ff);

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      length_in  = length_ff;
      desc_in    = desc_ff;
      field_in   = field_ff;
      sum_a_in   = sum_a_ff;
      sum_b_in   = sum_b_ff;
      trailer_in = trailer_ff;
      angle_in   = angle_ff;
      flags_in   = flags_ff;
      if (req_fire) begin
         unique case (phase_ff)
            PH_HUNT1: begin
               if (rx == SYNC_FIRST) begin
                  sum_a_in = SYNC_FIRST;
                  sum_b_in = SYNC_FIRST;
                  phase_in = PH_HUNT2;
               end
            end
            PH_HUNT2: begin
               priority if (rx == SYNC_SECOND) begin
                  sum_a_in = add_a;
                  sum_b_in = add_b;
                  phase_in = PH_DESC;
               end else if (rx == SYNC_FIRST) begin
                  // A repeated first sync byte restarts the sums.
                  sum_a_in = SYNC_FIRST;
                  sum_b_in = SYNC_FIRST;
               end else begin
                  phase_in = PH_HUNT1;
               end
            end
            PH_DESC: begin
               sum_a_in = add_a;
               sum_b_in = add_b;
               desc_in  = rx;
               field_in = '0;
               for (int i = 0; i < ANGLE_COUNT; i++) begin
                  angle_in[i] = '0;
               end
               flags_in = '0;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               sum_a_in  = add_a;
               sum_b_in  = add_b;
               length_in = rx;
               pos_in    = '0;
               phase_in  = (rx == 8'd0) ? PH_CK1 : PH_BODY;
            end
            PH_BODY: begin
               sum_a_in = add_a;
               sum_b_in = add_b;
               priority if (pos_ff == POS_FIELD) begin
                  field_in = rx;
               end else if (pos_ff >= POS_ANGLE_LO && pos_ff < POS_FLAGS_LO) begin
                  angle_in[angle_idx] = {angle_ff[angle_idx][23:0], rx};
               end else if (pos_ff == POS_FLAGS_LO || pos_ff == POS_FLAGS_HI) begin
                  flags_in = {flags_ff[7:0], rx};
               end else begin
                  // Payload byte 0 and bytes beyond the flags word only feed
                  // the checksum.
               end
               pos_in = pos_next[7:0];
               if (pos_next >= {1'b0, length_ff}) begin
                  phase_in = PH_CK1;
               end
            end
            PH_CK1: begin
               trailer_in = rx;
               phase_in   = PH_CK2;
            end
            PH_CK2: begin
               pos_in   = '0;
               phase_in = PH_HUNT1;
            end
            default: begin
               phase_in = PH_HUNT1;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      length_ff  <= length_in;
      desc_ff    <= desc_in;
      field_ff   <= field_in;
      sum_a_ff   <= sum_a_in;
      sum_b_ff   <= sum_b_in;
      trailer_ff <= trailer_in;
      angle_ff   <= angle_in;
      flags_ff   <= flags_in;
   end

   // Result capture; angles and flags are reported only for Euler packets.
   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff       <= kind;
         ck_ok_ff      <= ck_ok;
         out_desc_ff   <= desc_ff;
         out_field_ff  <= field_ff;
         out_length_ff <= length_ff;
         if (kind == KIND_EULER) begin
            out_roll_ff  <= angle_ff[0];
            out_pitch_ff <= angle_ff[1];
            out_yaw_ff   <= angle_ff[2];
            out_flags_ff <= flags_ff;
         end else begin
            out_roll_ff  <= '0;
            out_pitch_ff <= '0;
            out_yaw_ff   <= '0;
            out_flags_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {ck_ok_ff, kind_ff};
   assign rsp_tdata  = {out_flags_ff, out_yaw_ff, out_pitch_ff, out_roll_ff,
                        out_length_ff, out_field_ff, out_desc_ff};

`ifndef NO_ASSERTIONS
   a_emit_fills: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("last trailer byte did not produce a result");

   a_rsp_from_trailer: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(emit))
      else $error("result appeared without a finished packet");

   a_body_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (pos_ff < length_ff))
      else $error("payload position ran past the length");

   a_non_euler_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff != KIND_EULER) |-> (rsp_tdata[135:24] == '0))
      else $error("angle or flag data reported for a non-Euler packet");
`endif

endmodule

`default_nettype wire
